// ===== design/tlkv_pkg.sv =====
// ----------------------------------------------------------------------------
// tlkv_pkg: shared types and constants of the tagged key-value table
// Sizes, operation and status codes, and the match result bundle.
// ----------------------------------------------------------------------------
package tlkv_pkg;

   localparam int ENTRIES   = 16;
   localparam int IDX_W     = $clog2(ENTRIES);
   localparam int CNT_W     = $clog2(ENTRIES + 1);
   localparam int KEY_NBYTES = 8;
   localparam int KEY_W     = 64;
   localparam int VAL_W     = 64;
   localparam int TAG_W     = 8;
   localparam int SUFFIX_W  = 3;
   localparam int OP_W      = 2;
   localparam int STATUS_W  = 2;
   localparam int LIMIT_W   = 5;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_GET    = 2'd1;
   localparam logic [OP_W-1:0] OP_SCAN   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_UPDATED  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_APPENDED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_READ     = 2'd3;

   typedef logic [ENTRIES-1:0][TAG_W-1:0] tag_array_type;
   typedef logic [ENTRIES-1:0][KEY_W-1:0] key_array_type;

   typedef struct packed {
      logic             hit;
      logic [IDX_W-1:0] idx;
   } match_type;

endpackage

// ===== design/tlkv_match.sv =====
// ----------------------------------------------------------------------------
// tlkv_match: parallel tag and key-suffix compare over all held entries
// Returns whether any held entry matches and the lowest matching index.
// ----------------------------------------------------------------------------
module tlkv_match
   import tlkv_pkg::*;
(
   input  tag_array_type       entry_tags,
   input  key_array_type       entry_keys,
   input  logic [CNT_W-1:0]    fill_count,
   input  logic [SUFFIX_W-1:0] suffix_start,
   input  logic [KEY_W-1:0]    key,
   input  logic [TAG_W-1:0]    tag,
   output match_type           match
);

   logic [KEY_W-1:0]   cmp_mask;
   logic [ENTRIES-1:0] hit_vec;

   // Byte 0 is most significant: keep the low (KEY_NBYTES - suffix_start) bytes.
   always_comb begin
      for (int j = 0; j < KEY_NBYTES; j++) begin
         cmp_mask[j*8 +: 8] = (({1'b0, suffix_start} + 4'(j)) < 4'(KEY_NBYTES)) ? 8'hFF : 8'h00;
      end
   end

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         hit_vec[i] = (CNT_W'(i) < fill_count) && (entry_tags[i] == tag) &&
                      (((entry_keys[i] ^ key) & cmp_mask) == '0);
      end
   end

   // Lowest index wins.
   always_comb begin
      match.hit = |hit_vec;
      match.idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            match.idx = IDX_W'(i);
         end
      end
   end

endmodule

// ===== design/tagged_leaf_kv_store_unit.sv =====
// ----------------------------------------------------------------------------
// tagged_leaf_kv_store_unit: tag-filtered associative key-value table
// Sixteen-entry insert / get / scan table with stream request and response.
// ----------------------------------------------------------------------------
// A request transfer is captured in an input register; from there it is
// compared against all held entries at once and its response is written to
// the response register, so insert, get and unused codes give one response
// each; the next request is taken as that response is written. A scan emits
// min(max(scan_limit,1), entries held) values, one per response, read through the
// single read port, or one empty response if none are held; the input register holds
// the scan request until its last value has been loaded. Back-pressure on the
// response side stalls the unit. An entry matches when its tag is equal and
// the key bytes from byte suffix_start (byte 0 most significant) onward are
// equal; suffix_start runs from 0 to 7, so at least the lowest key byte always
// takes part. Write suffix_start only while the unit is idle. Entries
// are undefined after reset; only entries below the fill count are read, so
// no clearing pass is needed.
// ----------------------------------------------------------------------------
module tagged_leaf_kv_store_unit
   import tlkv_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // configuration
   input  logic                csr_write_enable,
   input  logic [SUFFIX_W-1:0] csr_write_data,     // suffix_start
   // request stream
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [143:0]        req_tdata,  // key[63:0], value[127:64], tag[135:128],
                                           // scan_limit[140:136], zero fill
   input  logic [OP_W-1:0]     req_tuser,  // operation[1:0]
   // response stream
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [71:0]         rsp_tdata,  // result_value[63:0], entry_count[68:64],
                                           // zero fill
   output logic [2:0]          rsp_tuser,  // found[0], status[2:1]
   output logic                rsp_tlast   // last
);

   // configuration register
   logic [SUFFIX_W-1:0] suffix_start_ff;

   // table storage
   tag_array_type              entry_tags_ff;
   key_array_type              entry_keys_ff;
   logic [VAL_W-1:0]           entry_values_ff [ENTRIES];
   logic [CNT_W-1:0]           fill_count_ff, fill_count_in;

   // input register
   logic                       cur_valid_ff;
   logic [OP_W-1:0]            cur_op_ff;
   logic [KEY_W-1:0]           cur_key_ff;
   logic [VAL_W-1:0]           cur_value_ff;
   logic [TAG_W-1:0]           cur_tag_ff;
   logic [LIMIT_W-1:0]         cur_limit_ff;
   logic [IDX_W-1:0]           scan_idx_ff;

   // response register
   logic                       rsp_valid_ff;
   logic [VAL_W-1:0]           rsp_value_ff, rsp_value_in;
   logic                       rsp_found_ff, rsp_found_in;
   logic [STATUS_W-1:0]        rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]           rsp_count_ff;
   logic                       rsp_last_ff, rsp_last_in;

   match_type                  match;
   logic                       produce, item_done, req_fire, table_full;
   logic [LIMIT_W-1:0]         limit_eff;
   logic [CNT_W-1:0]           scan_n;
   logic                       scan_last;
   logic [IDX_W-1:0]           rd_idx, wr_idx;
   logic [VAL_W-1:0]           rd_value;
   logic                       wr_value_en, wr_entry_en;

   // ---------------------------------------------------------------------
   // Compare the held request against every entry.
   // ---------------------------------------------------------------------
   tlkv_match u_match (
      .entry_tags   (entry_tags_ff),
      .entry_keys   (entry_keys_ff),
      .fill_count   (fill_count_ff),
      .suffix_start (suffix_start_ff),
      .key          (cur_key_ff),
      .tag          (cur_tag_ff),
      .match        (match)
   );

   // Advance when a request is held and the response register is free or
   // being drained this cycle.
   assign produce    = cur_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign item_done  = produce && rsp_last_in;
   assign req_tready = !cur_valid_ff || item_done;
   assign req_fire   = req_tvalid && req_tready;
   assign table_full = (fill_count_ff == CNT_W'(ENTRIES));

   // Scan length: limit zero counts as one, then saturate at entries held.
   assign limit_eff = (cur_limit_ff == '0) ? LIMIT_W'(1) : cur_limit_ff;
   always_comb begin
      if (CNT_W'(limit_eff) > fill_count_ff) begin
         scan_n = fill_count_ff;
      end else begin
         scan_n = CNT_W'(limit_eff);
      end
   end
   assign scan_last = ((CNT_W'(scan_idx_ff) + CNT_W'(1)) == scan_n);

   // Single read port on the value store: scan position or match index.
   assign rd_idx   = (cur_op_ff == OP_SCAN) ? scan_idx_ff : match.idx;
   assign rd_value = entry_values_ff[rd_idx];

   // ---------------------------------------------------------------------
   // Response and table update for the held request.
   // ---------------------------------------------------------------------
   always_comb begin
      rsp_value_in  = '0;
      rsp_found_in  = 1'b0;
      rsp_status_in = ST_READ;
      rsp_last_in   = 1'b1;
      fill_count_in = fill_count_ff;
      wr_value_en   = 1'b0;
      wr_entry_en   = 1'b0;
      wr_idx        = match.idx;
      case (cur_op_ff)
         OP_INSERT: begin
            if (match.hit) begin
               // overwrite the value of the matching entry
               wr_value_en   = 1'b1;
               rsp_value_in  = cur_value_ff;
               rsp_found_in  = 1'b1;
               rsp_status_in = ST_UPDATED;
            end else if (table_full) begin
               rsp_status_in = ST_FULL;
            end else begin
               // append at the fill position
               wr_idx        = fill_count_ff[IDX_W-1:0];
               wr_value_en   = 1'b1;
               wr_entry_en   = 1'b1;
               fill_count_in = fill_count_ff + CNT_W'(1);
               rsp_value_in  = cur_value_ff;
               rsp_status_in = ST_APPENDED;
            end
         end
         OP_GET: begin
            if (match.hit) begin
               rsp_value_in = rd_value;
               rsp_found_in = 1'b1;
            end
         end
         OP_SCAN: begin
            if (scan_n != '0) begin
               rsp_value_in = rd_value;
               rsp_found_in = 1'b1;
               rsp_last_in  = scan_last;
            end
         end
         default: begin
            // unused code: read-done with nothing found
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         suffix_start_ff <= '0;
      end else if (csr_write_enable) begin
         suffix_start_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_count_ff <= '0;
      end else if (produce) begin
         fill_count_ff <= fill_count_in;
      end
   end

   // Entry storage has no reset: only entries below the fill count are read.
   always_ff @(posedge clock) begin
      if (produce && wr_value_en) begin
         entry_values_ff[wr_idx] <= cur_value_ff;
      end
      if (produce && wr_entry_en) begin
         entry_tags_ff[wr_idx] <= cur_tag_ff;
         entry_keys_ff[wr_idx] <= cur_key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         scan_idx_ff  <= '0;
      end else begin
         if (req_fire) begin
            cur_valid_ff <= 1'b1;
         end else if (item_done) begin
            cur_valid_ff <= 1'b0;
         end
         // step through the table during a scan, rewind when the request retires
         if (item_done) begin
            scan_idx_ff <= '0;
         end else if (produce && (cur_op_ff == OP_SCAN)) begin
            scan_idx_ff <= scan_idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cur_op_ff    <= req_tuser;
         cur_key_ff   <= req_tdata[63:0];
         cur_value_ff <= req_tdata[127:64];
         cur_tag_ff   <= req_tdata[135:128];
         cur_limit_ff <= req_tdata[140:136];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (produce) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (produce) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_found_ff  <= rsp_found_in;
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= fill_count_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_count_ff, rsp_value_ff};
   assign rsp_tuser  = {rsp_status_ff, rsp_found_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== design/tlkv_checker.sv =====
// ----------------------------------------------------------------------------
// tlkv_checker: port-level checks of the tagged key-value table
// Watches the response stream for consistent status, count and handshake.
// ----------------------------------------------------------------------------
module tlkv_checker
   import tlkv_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [71:0]         rsp_tdata,
   input logic [2:0]          rsp_tuser,
   input logic                rsp_tlast
);

   // Reset empties the response register.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // Hold a stalled response.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled response changed");

   // Entry count never exceeds the table size.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[68:64] <= 5'(ENTRIES))
      else $error("entry count beyond table size");

   // A rejected insert reports a full table, nothing found, zero value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[2:1] == ST_FULL) |->
         (rsp_tdata[68:64] == 5'(ENTRIES)) && !rsp_tuser[0] && (rsp_tdata[63:0] == '0)
         && rsp_tlast)
      else $error("inconsistent full response");

   // Non-final responses only come from a scan with values found.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> (rsp_tuser[2:1] == ST_READ) && rsp_tuser[0])
      else $error("non-final response outside a scan");

endmodule

bind tagged_leaf_kv_store_unit tlkv_checker u_tlkv_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
